>>> hw/rtl/iirdf2_pkg.sv
`default_nettype none
package iirdf2_pkg;

   // Q16.16 sample and coefficient width
   localparam int unsigned DATA_W = 32;
   // Accumulator holds up to three saturated terms exactly
   localparam int unsigned ACC_W = 36;
   // Preset ratio divider: dividend (2*|sum a|<<16 + |sum b|) and divisor (2*|sum b|)
   localparam int unsigned DIV_NUM_W = 51;
   localparam int unsigned DIV_DEN_W = 35;
   localparam int unsigned DIV_CNT_W = 6;
   // Coefficient sums
   localparam int unsigned SUM_W = 34;

   // Configuration register indexes
   localparam logic [2:0] REG_TAP_COUNT = 3'd0;
   localparam logic [2:0] REG_COEF_A0   = 3'd1;
   localparam logic [2:0] REG_RECIP_A0  = 3'd2;
   localparam logic [2:0] REG_COEF_A1   = 3'd3;
   localparam logic [2:0] REG_COEF_A2   = 3'd4;
   localparam logic [2:0] REG_COEF_B0   = 3'd5;
   localparam logic [2:0] REG_COEF_B1   = 3'd6;
   localparam logic [2:0] REG_COEF_B2   = 3'd7;

   // Input item kinds
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_PRESET = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Y_MUL,
      ST_Y_ADD,
      ST_Y_SCALE,
      ST_Y_STORE,
      ST_P_SUM,
      ST_P_START,
      ST_P_DIV,
      ST_P_MUL,
      ST_P_STORE,
      ST_T_MULB,
      ST_T_MULA,
      ST_T_SUB,
      ST_FIN
   } state_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(signed'(32'sh7FFF_FFFF));
      lo = ACC_W'(signed'(32'sh8000_0000));
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   // Round a raw Q32.32 product to Q16.16, ties upward, then saturate
   function automatic logic signed [DATA_W-1:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      logic signed [47:0] r;
      t = p + 64'sd32768;
      r = t[63:16];
      if (r > 48'sh0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -48'sh0000_8000_0000) begin
         return 32'sh8000_0000;
      end
      return r[DATA_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/iir_filter_df2_transposed.sv
// Transposed direct-form-2 IIR filter of order one or two in signed Q16.16, built around
// one shared 32x32 multiplier under a small sequencer. A sample item (req_tuser 0) takes
// two multiplies for the output, then one multiply pair per delay state. A preset item
// (req_tuser 1) loads the delay states for a steady output equal to the input value,
// through the bit-serial divider that forms sum(a)/sum(b) as 51 quotient bits and then
// flags the end; when sum(b) is zero the divider is skipped, the states are cleared and
// rsp_tuser flags the fault. A result that waits on rsp_tready holds the sequencer in its
// last state. One item is in work at a time; req_tready is high only while the sequencer
// is idle and out of reset, and a finished result may wait in the output register while
// the next item is taken.
`default_nettype none
module iir_filter_df2_transposed #(
   parameter int MAX_TAPS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] filtered
   output logic             rsp_tuser,   // [0] preset_fault
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int IDX_W = (MAX_TAPS > 2) ? 2 : 1;

   iirdf2_pkg::state_type state_ff, state_in;

   logic [1:0]         tap_count_ff;
   logic signed [31:0] coef_a0_ff, recip_a0_ff, coef_a1_ff, coef_a2_ff;
   logic signed [31:0] coef_b0_ff, coef_b1_ff, coef_b2_ff;

   logic signed [31:0] d_ff [MAX_TAPS];
   logic               action_ff;
   logic signed [31:0] value_ff, xv_ff, yv_ff, ratio_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic signed [iirdf2_pkg::ACC_W-1:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [iirdf2_pkg::SUM_W-1:0] sa_ff, sb_ff;
   logic               fault_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_fault_ff;

   logic signed [31:0] qv;
   logic signed [31:0] mul_a, mul_b;
   logic [IDX_W-1:0]   last_idx;
   logic               idx_last, idx_first;
   logic signed [31:0] coef_ai, coef_bi, carry;
   logic               accept, fin_load;
   logic               div_start, div_done;
   logic [iirdf2_pkg::DIV_NUM_W-1:0] div_quo, div_num;
   logic [iirdf2_pkg::DIV_DEN_W-1:0] div_den;
   logic [iirdf2_pkg::SUM_W-1:0]     mag_a, mag_b;
   logic signed [31:0] ratio;
   logic               ratio_neg;

   assign qv = iirdf2_pkg::qround(prod_ff);

   // Clamp the tap count to 2..MAX_TAPS, as a last delay index
   always_comb begin
      if (tap_count_ff < 2'd2) begin
         last_idx = IDX_W'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         last_idx = IDX_W'(MAX_TAPS - 1);
      end else begin
         last_idx = IDX_W'(tap_count_ff - 2'd1);
      end
   end

   assign idx_last  = idx_ff == last_idx;
   assign idx_first = idx_ff == IDX_W'(1);
   assign coef_ai   = (int'(idx_ff) == 2) ? coef_a2_ff : coef_a1_ff;
   assign coef_bi   = (int'(idx_ff) == 2) ? coef_b2_ff : coef_b1_ff;
   assign carry     = idx_last ? 32'sd0 : d_ff[IDX_W'(idx_ff + 1'b1)];

   // Divider operands and the saturated signed ratio
   assign mag_a   = sa_ff[iirdf2_pkg::SUM_W-1] ? iirdf2_pkg::SUM_W'(-sa_ff) : sa_ff;
   assign mag_b   = sb_ff[iirdf2_pkg::SUM_W-1] ? iirdf2_pkg::SUM_W'(-sb_ff) : sb_ff;
   assign div_num = iirdf2_pkg::DIV_NUM_W'({mag_a, 17'd0})
                  + iirdf2_pkg::DIV_NUM_W'(mag_b);
   assign div_den = iirdf2_pkg::DIV_DEN_W'({mag_b, 1'b0});
   assign ratio_neg = sa_ff[iirdf2_pkg::SUM_W-1] != sb_ff[iirdf2_pkg::SUM_W-1];

   always_comb begin
      if (ratio_neg) begin
         if (div_quo >= iirdf2_pkg::DIV_NUM_W'(33'h0_8000_0000)) begin
            ratio = 32'sh8000_0000;
         end else begin
            ratio = -signed'(div_quo[31:0]);
         end
      end else if (div_quo > iirdf2_pkg::DIV_NUM_W'(32'h7FFF_FFFF)) begin
         ratio = 32'sh7FFF_FFFF;
      end else begin
         ratio = signed'(div_quo[31:0]);
      end
   end

   iirdf2_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iirdf2_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == iirdf2_pkg::ACT_PRESET) ? iirdf2_pkg::ST_P_SUM
                                                                : iirdf2_pkg::ST_Y_MUL;
            end
         end
         iirdf2_pkg::ST_Y_MUL:   state_in = iirdf2_pkg::ST_Y_ADD;
         iirdf2_pkg::ST_Y_ADD:   state_in = iirdf2_pkg::ST_Y_SCALE;
         iirdf2_pkg::ST_Y_SCALE: state_in = iirdf2_pkg::ST_Y_STORE;
         iirdf2_pkg::ST_Y_STORE: state_in = iirdf2_pkg::ST_T_MULB;
         iirdf2_pkg::ST_P_SUM:   state_in = iirdf2_pkg::ST_P_START;
         iirdf2_pkg::ST_P_START: begin
            state_in = (sb_ff == '0) ? iirdf2_pkg::ST_FIN : iirdf2_pkg::ST_P_DIV;
         end
         iirdf2_pkg::ST_P_DIV: begin
            if (div_done) begin
               state_in = iirdf2_pkg::ST_P_MUL;
            end
         end
         iirdf2_pkg::ST_P_MUL:   state_in = iirdf2_pkg::ST_P_STORE;
         iirdf2_pkg::ST_P_STORE: state_in = iirdf2_pkg::ST_T_MULB;
         iirdf2_pkg::ST_T_MULB:  state_in = iirdf2_pkg::ST_T_MULA;
         iirdf2_pkg::ST_T_MULA:  state_in = iirdf2_pkg::ST_T_SUB;
         iirdf2_pkg::ST_T_SUB: begin
            if (action_ff == iirdf2_pkg::ACT_PRESET) begin
               state_in = idx_first ? iirdf2_pkg::ST_FIN : iirdf2_pkg::ST_T_MULB;
            end else begin
               state_in = idx_last ? iirdf2_pkg::ST_FIN : iirdf2_pkg::ST_T_MULB;
            end
         end
         iirdf2_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = iirdf2_pkg::ST_IDLE;
            end
         end
         default: state_in = iirdf2_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: multiplier operands and strobes
   always_comb begin
      mul_a     = value_ff;
      mul_b     = coef_b0_ff;
      div_start = 1'b0;
      fin_load  = 1'b0;
      unique case (state_ff)
         iirdf2_pkg::ST_Y_SCALE: begin
            mul_a = recip_a0_ff;
            mul_b = iirdf2_pkg::sat32(acc_ff);
         end
         iirdf2_pkg::ST_P_START: div_start = sb_ff != '0;
         iirdf2_pkg::ST_P_MUL: begin
            mul_a = value_ff;
            mul_b = ratio_ff;
         end
         iirdf2_pkg::ST_T_MULB: begin
            mul_a = coef_bi;
            mul_b = xv_ff;
         end
         iirdf2_pkg::ST_T_MULA: begin
            mul_a = coef_ai;
            mul_b = yv_ff;
         end
         iirdf2_pkg::ST_FIN: fin_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   assign accept = (state_ff == iirdf2_pkg::ST_IDLE) && req_tvalid;

   // Shared multiplier, raw product registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_tuser;
         value_ff  <= req_tdata;
      end
      unique case (state_ff)
         iirdf2_pkg::ST_Y_ADD: begin
            acc_ff <= iirdf2_pkg::ACC_W'(d_ff[1]) + iirdf2_pkg::ACC_W'(qv);
         end
         iirdf2_pkg::ST_Y_STORE: begin
            yv_ff  <= qv;
            xv_ff  <= value_ff;
            idx_ff <= IDX_W'(1);
         end
         iirdf2_pkg::ST_P_SUM: begin
            sa_ff <= iirdf2_pkg::SUM_W'(coef_a0_ff) + iirdf2_pkg::SUM_W'(coef_a1_ff)
                   + ((int'(last_idx) == 2) ? iirdf2_pkg::SUM_W'(coef_a2_ff) : '0);
            sb_ff <= iirdf2_pkg::SUM_W'(coef_b0_ff) + iirdf2_pkg::SUM_W'(coef_b1_ff)
                   + ((int'(last_idx) == 2) ? iirdf2_pkg::SUM_W'(coef_b2_ff) : '0);
         end
         iirdf2_pkg::ST_P_DIV: begin
            ratio_ff <= ratio;
         end
         iirdf2_pkg::ST_P_STORE: begin
            xv_ff  <= qv;
            yv_ff  <= value_ff;
            idx_ff <= last_idx;
         end
         iirdf2_pkg::ST_T_MULB: begin
            acc_ff <= iirdf2_pkg::ACC_W'(carry);
         end
         iirdf2_pkg::ST_T_MULA: begin
            acc_ff <= acc_ff + iirdf2_pkg::ACC_W'(qv);
         end
         iirdf2_pkg::ST_T_SUB: begin
            if (action_ff == iirdf2_pkg::ACT_PRESET) begin
               idx_ff <= idx_ff - 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Delay states and fault flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_TAPS; k++) begin
            d_ff[k] <= '0;
         end
         fault_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            iirdf2_pkg::ST_IDLE: fault_ff <= 1'b0;
            iirdf2_pkg::ST_Y_STORE: d_ff[0] <= qv;
            iirdf2_pkg::ST_P_START: begin
               if (sb_ff == '0) begin
                  for (int k = 0; k < MAX_TAPS; k++) begin
                     d_ff[k] <= '0;
                  end
                  fault_ff <= 1'b1;
               end
            end
            iirdf2_pkg::ST_P_STORE: d_ff[0] <= value_ff;
            iirdf2_pkg::ST_T_SUB: begin
               d_ff[idx_ff] <= iirdf2_pkg::sat32(acc_ff - iirdf2_pkg::ACC_W'(qv));
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= 2'd3;
         coef_a0_ff   <= 32'sd65536;
         recip_a0_ff  <= 32'sd65536;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         coef_b0_ff   <= 32'sd65536;
         coef_b1_ff   <= '0;
         coef_b2_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            iirdf2_pkg::REG_TAP_COUNT: tap_count_ff <= csr_wdata[1:0];
            iirdf2_pkg::REG_COEF_A0:   coef_a0_ff   <= csr_wdata;
            iirdf2_pkg::REG_RECIP_A0:  recip_a0_ff  <= csr_wdata;
            iirdf2_pkg::REG_COEF_A1:   coef_a1_ff   <= csr_wdata;
            iirdf2_pkg::REG_COEF_A2:   coef_a2_ff   <= csr_wdata;
            iirdf2_pkg::REG_COEF_B0:   coef_b0_ff   <= csr_wdata;
            iirdf2_pkg::REG_COEF_B1:   coef_b1_ff   <= csr_wdata;
            iirdf2_pkg::REG_COEF_B2:   coef_b2_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Output register: load the finished item, drop it once taken
   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_data_ff  <= d_ff[0];
         rsp_fault_ff <= fault_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iirdf2_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold off the input during reset
   assign req_tready = (state_ff == iirdf2_pkg::ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fault_ff;

endmodule
`default_nettype wire

>>> hw/rtl/iirdf2_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module iirdf2_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [iirdf2_pkg::DIV_NUM_W-1:0]    dividend,
   input  wire logic [iirdf2_pkg::DIV_DEN_W-1:0]    divisor,
   output logic                                     done,
   output logic [iirdf2_pkg::DIV_NUM_W-1:0]         quotient
);

   logic [iirdf2_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [iirdf2_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [iirdf2_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [iirdf2_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [iirdf2_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [iirdf2_pkg::DIV_DEN_W:0]   trial;
   logic                             fits;

   // Shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, num_ff[iirdf2_pkg::DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = iirdf2_pkg::DIV_CNT_W'(iirdf2_pkg::DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[iirdf2_pkg::DIV_NUM_W-2:0], 1'b0};
         rem_in = fits ? iirdf2_pkg::DIV_DEN_W'(trial - {1'b0, den_ff})
                       : trial[iirdf2_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[iirdf2_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == iirdf2_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
